FILE: src/ir8_pkg.sv
// ----------------------------------------------------------------------------
// ir8_pkg
// Shared types and constants for the 8x8 intra residual block: block
// geometry, request and mode codes, and the request and response payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package ir8_pkg;

  // Block geometry and sample widths
  localparam int PIXEL_BITS  = 8;
  localparam int BLOCK_SIZE  = 8;
  localparam int RESID_BITS  = PIXEL_BITS + 1;
  localparam int TOP_COUNT   = 2 * BLOCK_SIZE + 1;
  localparam int LEFT_COUNT  = BLOCK_SIZE + 1;
  localparam int PIXELS      = BLOCK_SIZE * BLOCK_SIZE;
  localparam int COORD_BITS  = $clog2(BLOCK_SIZE);
  localparam int POS_BITS    = $clog2(PIXELS);
  localparam int TOP_IDX_W   = $clog2(TOP_COUNT);
  localparam int LEFT_IDX_W  = $clog2(LEFT_COUNT);
  localparam int INDEX_BITS  = 5;
  localparam int MODE_BITS   = 3;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_TOP   = 2'd0,
    REQ_LEFT  = 2'd1,
    REQ_DC    = 2'd2,
    REQ_PIXEL = 2'd3
  } req_type_t;

  // Prediction modes
  typedef enum logic [MODE_BITS-1:0] {
    MODE_VERTICAL   = 3'd0,
    MODE_HORIZONTAL = 3'd1,
    MODE_DC         = 3'd2,
    MODE_DIAG_DL    = 3'd3,
    MODE_DIAG_DR    = 3'd4,
    MODE_VERT_RIGHT = 3'd5,
    MODE_HORIZ_DOWN = 3'd6,
    MODE_VERT_LEFT  = 3'd7
  } mode_t;

  // Request payload
  typedef struct packed {
    req_type_t              req_type;
    logic [INDEX_BITS-1:0]  index;
    logic [PIXEL_BITS-1:0]  value;
    mode_t                  mode;
  } req_t;

  // Response payload
  typedef struct packed {
    logic signed [RESID_BITS-1:0] residual;
    logic                         block_end;
  } rsp_t;

endpackage

`default_nettype wire

FILE: src/intra_residual_8x8.sv
// ----------------------------------------------------------------------------
// intra_residual_8x8
// Intra prediction residuals for an 8x8 block streamed in raster order.
// ----------------------------------------------------------------------------
// Neighbour, DC and pixel requests arrive on req_*; every pixel request gives
// one residual on rsp_*, neighbour and DC writes give none. The block takes
// one request per clock: the prediction is a single select among buffered
// samples and one subtraction, registered into the response register, so a
// pixel's residual appears the cycle after it is taken. Requests keep flowing
// while a response waits as long as rsp_ready takes it in the same cycle;
// a stalled response holds req_ready low. The mode is latched at each
// block's first pixel, and block_end marks the 64th residual. No clearing
// pass follows reset; neighbours must be written before they are used.
// ----------------------------------------------------------------------------
`default_nettype none

module intra_residual_8x8 (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ir8_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ir8_pkg::rsp_t rsp_data
);

  localparam int PB = ir8_pkg::PIXEL_BITS;
  localparam int BS = ir8_pkg::BLOCK_SIZE;
  localparam int CB = ir8_pkg::COORD_BITS;
  localparam int TW = ir8_pkg::TOP_IDX_W;
  localparam int LW = ir8_pkg::LEFT_IDX_W;
  localparam int RB = ir8_pkg::RESID_BITS;

  // Prediction source
  typedef enum logic [2:0] {
    SRC_TOP,
    SRC_LEFT,
    SRC_DC,
    SRC_UP,
    SRC_UR,
    SRC_UL,
    SRC_PREV
  } src_t;

  // Neighbour stores and running state
  logic [PB-1:0]               top_nb  [ir8_pkg::TOP_COUNT];
  logic [PB-1:0]               left_nb [ir8_pkg::LEFT_COUNT];
  logic [PB-1:0]               dc_avg;
  // pixel history: pix_line[k] is the pixel k+1 positions back
  logic [PB-1:0]               pix_line [BS+1];
  logic [ir8_pkg::POS_BITS-1:0] pos;
  ir8_pkg::mode_t              block_mode;

  logic                        req_fire;
  logic                        pix_fire;
  ir8_pkg::mode_t              cur_mode;
  logic [CB-1:0]               row;
  logic [CB-1:0]               col;
  logic                        row0;
  logic                        col0;
  logic                        col_last;
  src_t                        src;
  logic [TW-1:0]               top_idx;
  logic [LW-1:0]               left_idx;
  logic [TW-1:0]               col_t;
  logic [TW-1:0]               row_t;
  logic [LW-1:0]               row_l;
  logic [PB-1:0]               pred;
  logic [RB-1:0]               diff;

  // Handshake: the response register parts the two sides
  assign req_ready = !rsp_valid || rsp_ready;
  assign req_fire  = req_valid && req_ready;
  assign pix_fire  = req_fire && (req_data.req_type == ir8_pkg::REQ_PIXEL);

  // Position decode; mode is taken from the request at a block's first pixel
  assign row      = pos[ir8_pkg::POS_BITS-1:CB];
  assign col      = pos[CB-1:0];
  assign row0     = (row == '0);
  assign col0     = (col == '0);
  assign col_last = (col == CB'(BS - 1));
  assign cur_mode = (pos == '0) ? req_data.mode : block_mode;
  assign col_t    = TW'(col);
  assign row_t    = TW'(row);
  assign row_l    = LW'(row);

  // Choose prediction source and neighbour index
  always_comb begin
    src      = SRC_DC;
    top_idx  = '0;
    left_idx = '0;
    unique case (cur_mode)
      ir8_pkg::MODE_VERTICAL: begin
        if (row0) begin
          src     = SRC_TOP;
          top_idx = col_t + TW'(1);
        end else begin
          src = SRC_UP;
        end
      end
      ir8_pkg::MODE_HORIZONTAL: begin
        if (col0) begin
          src      = SRC_LEFT;
          left_idx = row_l + LW'(1);
        end else begin
          src = SRC_PREV;
        end
      end
      ir8_pkg::MODE_DC: begin
        src = SRC_DC;
      end
      ir8_pkg::MODE_DIAG_DL: begin
        if (row0) begin
          src     = SRC_TOP;
          top_idx = col_t + TW'(1);
        end else if (!col_last) begin
          src = SRC_UR;
        end else begin
          src     = SRC_TOP;
          top_idx = row_t + TW'(BS + 1);
        end
      end
      ir8_pkg::MODE_DIAG_DR: begin
        if (row0) begin
          src     = SRC_TOP;
          top_idx = col_t;
        end else if (col0) begin
          src      = SRC_LEFT;
          left_idx = row_l;
        end else begin
          src = SRC_UL;
        end
      end
      ir8_pkg::MODE_VERT_RIGHT: begin
        if (row0) begin
          src     = SRC_TOP;
          top_idx = col_t;
        end else if (row[0]) begin
          src = SRC_UP;
        end else if (col0) begin
          src      = SRC_LEFT;
          left_idx = row_l;
        end else begin
          src = SRC_UL;
        end
      end
      ir8_pkg::MODE_HORIZ_DOWN: begin
        if (row0) begin
          if (col[0]) begin
            src = SRC_PREV;
          end else begin
            src     = SRC_TOP;
            top_idx = col_t;
          end
        end else if (col0) begin
          src      = SRC_LEFT;
          left_idx = row_l;
        end else if (col[0]) begin
          src = SRC_PREV;
        end else begin
          src = SRC_UL;
        end
      end
      ir8_pkg::MODE_VERT_LEFT: begin
        if (row0) begin
          src     = SRC_TOP;
          top_idx = col_t + TW'(2);
        end else if (row[0]) begin
          src = SRC_UP;
        end else if (!col_last) begin
          src = SRC_UR;
        end else begin
          src     = SRC_TOP;
          top_idx = row_t + TW'(BS);
        end
      end
      default: begin
        src = SRC_DC;
      end
    endcase
  end

  // Prediction select and residual
  always_comb begin
    case (src)
      SRC_TOP:  pred = top_nb[top_idx];
      SRC_LEFT: pred = left_nb[left_idx];
      SRC_UP:   pred = pix_line[BS-1];
      SRC_UR:   pred = pix_line[BS-2];
      SRC_UL:   pred = pix_line[BS];
      SRC_PREV: pred = pix_line[0];
      default:  pred = dc_avg;
    endcase
  end

  assign diff = RB'({1'b0, req_data.value}) - RB'({1'b0, pred});

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      pos        <= '0;
      block_mode <= ir8_pkg::MODE_VERTICAL;
      dc_avg     <= '0;
    end else begin
      if (pix_fire) begin
        rsp_valid  <= 1'b1;
        block_mode <= cur_mode;
        pos        <= pos + 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (req_fire && req_data.req_type == ir8_pkg::REQ_DC) begin
        dc_avg <= req_data.value;
      end
    end
  end

  // Neighbour writes, pixel history and response payload
  always_ff @(posedge clk) begin
    if (req_fire) begin
      unique case (req_data.req_type)
        ir8_pkg::REQ_TOP: begin
          if (req_data.index < ir8_pkg::INDEX_BITS'(ir8_pkg::TOP_COUNT)) begin
            top_nb[req_data.index] <= req_data.value;
          end
        end
        ir8_pkg::REQ_LEFT: begin
          if (req_data.index < ir8_pkg::INDEX_BITS'(ir8_pkg::LEFT_COUNT)) begin
            left_nb[LW'(req_data.index)] <= req_data.value;
          end
        end
        ir8_pkg::REQ_PIXEL: begin
          pix_line[0] <= req_data.value;
          for (int k = 1; k <= BS; k++) begin
            pix_line[k] <= pix_line[k-1];
          end
          rsp_data.residual  <= $signed(diff);
          rsp_data.block_end <= (pos == ir8_pkg::POS_BITS'(ir8_pkg::PIXELS - 1));
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/ir8_checker.sv
// ----------------------------------------------------------------------------
// ir8_checker
// Port-level checks for intra_residual_8x8, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ir8_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input ir8_pkg::req_t req_data,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ir8_pkg::rsp_t rsp_data
);

  logic                         req_fire;
  logic                         rsp_fire;
  logic [ir8_pkg::POS_BITS-1:0] out_cnt;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // Count delivered residuals within a block
  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= '0;
    end else if (rsp_fire) begin
      out_cnt <= out_cnt + 1'b1;
    end
  end

  // A stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");

  // Free response register means the block takes requests
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid || rsp_ready |-> req_ready)
    else $error("request stalled with room to respond");

  // Every pixel gives a response next cycle
  a_pixel_rsp: assert property (@(posedge clk) disable iff (rst)
    req_fire && req_data.req_type == ir8_pkg::REQ_PIXEL |=> rsp_valid)
    else $error("pixel without response");

  // Neighbour and DC writes give no response
  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    req_fire && req_data.req_type != ir8_pkg::REQ_PIXEL && rsp_ready |=> !rsp_valid)
    else $error("response from a neighbour write");

  // End of block marks every 64th residual
  a_block_end: assert property (@(posedge clk) disable iff (rst)
    rsp_fire |-> rsp_data.block_end == (out_cnt == ir8_pkg::POS_BITS'(ir8_pkg::PIXELS - 1)))
    else $error("block_end misplaced");

endmodule

bind intra_residual_8x8 ir8_checker u_ir8_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req_data  (req_data),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: test/intra_residual_8x8_tb.sv
// ----------------------------------------------------------------------------
// intra_residual_8x8_tb
// Self-checking bench for the 8x8 intra residual block. Neighbour, DC and
// pixel requests are queued up front and fed through a valid/ready driver.
// A monitor predicts every residual from the accepted requests and checks
// the responses in order. Idling runs in four phases, and one long response
// hold-off backs the block up onto its request side.
// ----------------------------------------------------------------------------
module intra_residual_8x8_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 1700;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int LAST_COL     = ir8_pkg::BLOCK_SIZE - 1;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  ir8_pkg::req_t req_data  = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  ir8_pkg::rsp_t rsp_data;

  always #5 clk = ~clk;

  intra_residual_8x8 u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  // Stimulus and expected results
  ir8_pkg::req_t pending_reqs[$];
  ir8_pkg::rsp_t expected_residuals[$];
  int   total_items = 0;
  int   req_count   = 0;
  int   rsp_count   = 0;
  int   mismatches  = 0;
  int   mode_blocks [8] = '{default: 0};
  int   hold_left   = 0;
  bit   hold_done   = 1'b0;

  // Predictor state: neighbours, DC, previous row and current raster position
  logic [ir8_pkg::PIXEL_BITS-1:0] top_nb [ir8_pkg::TOP_COUNT]     = '{default: '0};
  logic [ir8_pkg::PIXEL_BITS-1:0] left_nb [ir8_pkg::LEFT_COUNT]   = '{default: '0};
  logic [ir8_pkg::PIXEL_BITS-1:0] above_row [ir8_pkg::BLOCK_SIZE] = '{default: '0};
  logic [ir8_pkg::PIXEL_BITS-1:0] dc_avg     = '0;
  logic [ir8_pkg::PIXEL_BITS-1:0] above_left = '0;
  logic [ir8_pkg::PIXEL_BITS-1:0] prev_pix   = '0;
  logic [ir8_pkg::POS_BITS-1:0]   raster_pos = '0;
  ir8_pkg::mode_t                 blk_mode   = ir8_pkg::MODE_VERTICAL;

  // Applies one request to the predictor; returns 1 with the residual for pixels
  function automatic bit predict_residual(input ir8_pkg::req_t r,
                                          output ir8_pkg::rsp_t res);
    logic [ir8_pkg::COORD_BITS-1:0] y;
    logic [ir8_pkg::COORD_BITS-1:0] x;
    logic [ir8_pkg::PIXEL_BITS-1:0] pred;
    logic [ir8_pkg::PIXEL_BITS-1:0] up;
    logic [ir8_pkg::PIXEL_BITS-1:0] ur;
    res = '0;
    case (r.req_type)
      ir8_pkg::REQ_TOP: begin
        if (r.index < ir8_pkg::TOP_COUNT) top_nb[r.index] = r.value;
        return 1'b0;
      end
      ir8_pkg::REQ_LEFT: begin
        if (r.index < ir8_pkg::LEFT_COUNT) left_nb[r.index] = r.value;
        return 1'b0;
      end
      ir8_pkg::REQ_DC: begin
        dc_avg = r.value;
        return 1'b0;
      end
      default: ;
    endcase

    // mode only counts at the block's first pixel
    if (raster_pos == 0) begin
      blk_mode = r.mode;
      mode_blocks[r.mode]++;
    end
    y  = raster_pos[ir8_pkg::POS_BITS-1:ir8_pkg::COORD_BITS];
    x  = raster_pos[ir8_pkg::COORD_BITS-1:0];
    up = above_row[x];
    ur = (x < LAST_COL) ? above_row[x + 1] : '0;

    case (blk_mode)
      ir8_pkg::MODE_VERTICAL:   pred = (y == 0) ? top_nb[x + 1] : up;
      ir8_pkg::MODE_HORIZONTAL: pred = (x == 0) ? left_nb[y + 1] : prev_pix;
      ir8_pkg::MODE_DC:         pred = dc_avg;
      ir8_pkg::MODE_DIAG_DL: begin
        if (y == 0)             pred = top_nb[x + 1];
        else if (x < LAST_COL)  pred = ur;
        else                    pred = top_nb[ir8_pkg::BLOCK_SIZE + 1 + y];
      end
      ir8_pkg::MODE_DIAG_DR: begin
        if (y == 0)      pred = top_nb[x];
        else if (x == 0) pred = left_nb[y];
        else             pred = above_left;
      end
      ir8_pkg::MODE_VERT_RIGHT: begin
        if (y == 0)      pred = top_nb[x];
        else if (y[0])   pred = up;
        else if (x == 0) pred = left_nb[y];
        else             pred = above_left;
      end
      ir8_pkg::MODE_HORIZ_DOWN: begin
        if (y == 0)      pred = x[0] ? prev_pix : top_nb[x];
        else if (x == 0) pred = left_nb[y];
        else             pred = x[0] ? prev_pix : above_left;
      end
      default: begin
        if (y == 0)            pred = top_nb[x + 2];
        else if (y[0])         pred = up;
        else if (x < LAST_COL) pred = ur;
        else                   pred = top_nb[ir8_pkg::BLOCK_SIZE + y];
      end
    endcase

    res.residual  = {1'b0, r.value} - {1'b0, pred};
    res.block_end = (raster_pos == ir8_pkg::PIXELS - 1);
    above_left    = above_row[x];
    above_row[x]  = r.value;
    prev_pix      = r.value;
    raster_pos    = raster_pos + 1'b1;
    return 1'b1;
  endfunction

  // Idling phases: none, sender only, receiver only, both
  function automatic int cur_phase();
    int p;
    p = (total_items == 0) ? 0 : (req_count * 4) / total_items;
    return (p > 3) ? 3 : p;
  endfunction

  function automatic bit roll(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Request driver
  always @(posedge clk) begin
    int pct;
    pct = (cur_phase() == 1) ? 64 : (cur_phase() == 3) ? 37 : 0;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (pending_reqs.size() != 0 && !roll(pct)) begin
        req_valid <= 1'b1;
        req_data  <= pending_reqs.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Long response hold-off while requests keep coming
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && req_count >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Response receiver
  always @(posedge clk) begin
    int pct;
    pct = (cur_phase() == 2) ? 64 : (cur_phase() == 3) ? 37 : 0;
    if (rst) rsp_ready <= 1'b0;
    else     rsp_ready <= (hold_left == 0) && !roll(pct);
  end

  task automatic log_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Monitor: predict on accepted requests, check accepted responses
  always @(posedge clk) begin
    ir8_pkg::rsp_t due;
    ir8_pkg::rsp_t calc;
    if (!rst) begin
      if (req_valid && req_ready) begin
        req_count <= req_count + 1;
        if (predict_residual(req_data, calc)) expected_residuals.push_back(calc);
      end
      if (rsp_valid && rsp_ready) begin
        rsp_count <= rsp_count + 1;
        if (expected_residuals.size() == 0) begin
          log_error($sformatf("%0t: unexpected response residual %0d block_end %0b",
                              $realtime, $signed(rsp_data.residual), rsp_data.block_end));
        end else begin
          due = expected_residuals.pop_front();
          if (rsp_data.residual !== due.residual || rsp_data.block_end !== due.block_end)
            log_error($sformatf(
              "%0t: response %0d: residual exp %0d got %0d, block_end exp %0b got %0b",
              $realtime, rsp_count, $signed(due.residual), $signed(rsp_data.residual),
              due.block_end, rsp_data.block_end));
        end
      end
    end
  end

  // Stimulus generation and end of run
  int gen_pos = 0;
  int counted = 0;

  task automatic push_req(input ir8_pkg::req_type_t t, input int idx, input int val,
                          input int md);
    ir8_pkg::req_t r;
    r.req_type = t;
    r.index    = idx[ir8_pkg::INDEX_BITS-1:0];
    r.value    = val[ir8_pkg::PIXEL_BITS-1:0];
    r.mode     = ir8_pkg::mode_t'(md[ir8_pkg::MODE_BITS-1:0]);
    pending_reqs.push_back(r);
    if (t == ir8_pkg::REQ_PIXEL) gen_pos = (gen_pos + 1) % ir8_pkg::PIXELS;
    // out-of-range neighbour writes are dropped by the block
    if (!((t == ir8_pkg::REQ_TOP && idx >= ir8_pkg::TOP_COUNT) ||
          (t == ir8_pkg::REQ_LEFT && idx >= ir8_pkg::LEFT_COUNT)))
      counted++;
  endtask

  initial begin
    int blk;
    int blk_md;
    int style;
    int base;
    int pick;
    int pix;
    blk    = 0;
    blk_md = ir8_pkg::MODE_DC;
    style  = 0;
    base   = 128;

    // Every neighbour written before any pixel reads it
    for (int i = 0; i < ir8_pkg::TOP_COUNT; i++)
      push_req(ir8_pkg::REQ_TOP, i, (i == 0) ? 255 : $urandom_range(255),
               $urandom_range(7));
    for (int i = 0; i < ir8_pkg::LEFT_COUNT; i++)
      push_req(ir8_pkg::REQ_LEFT, i,
               (i == ir8_pkg::LEFT_COUNT - 1) ? 0 : $urandom_range(255),
               $urandom_range(7));

    // Directed: dropped writes, DC extremes, largest residuals both ways
    push_req(ir8_pkg::REQ_TOP, 17, 8'hAA, 0);
    push_req(ir8_pkg::REQ_TOP, 31, 8'h55, 7);
    push_req(ir8_pkg::REQ_LEFT, 9, 8'hAA, 0);
    push_req(ir8_pkg::REQ_LEFT, 31, 8'h55, 7);
    push_req(ir8_pkg::REQ_DC, 0, 255, 0);
    push_req(ir8_pkg::REQ_PIXEL, 0, 0, ir8_pkg::MODE_DC);
    push_req(ir8_pkg::REQ_DC, 31, 0, 7);
    push_req(ir8_pkg::REQ_PIXEL, 31, 255, ir8_pkg::MODE_VERT_LEFT);
    push_req(ir8_pkg::REQ_TOP, 1, 0, 0);
    push_req(ir8_pkg::REQ_PIXEL, 0, 255, ir8_pkg::MODE_VERTICAL);

    // Random blocks: first eight walk through every mode, then any mode
    while (counted < ITEM_TARGET) begin
      if (gen_pos == 0) begin
        blk_md = (blk < 8) ? blk : $urandom_range(7);
        style  = $urandom_range(3);
        base   = $urandom_range(255);
        blk++;
      end
      // occasional neighbour or DC rewrite inside the block
      pick = $urandom_range(99);
      if (pick < 6)
        push_req(ir8_pkg::REQ_TOP, $urandom_range(31), $urandom_range(255),
                 $urandom_range(7));
      else if (pick < 10)
        push_req(ir8_pkg::REQ_LEFT, $urandom_range(31), $urandom_range(255),
                 $urandom_range(7));
      else if (pick < 12)
        push_req(ir8_pkg::REQ_DC, $urandom_range(31), $urandom_range(255),
                 $urandom_range(7));
      case (style)
        1:       pix = $urandom_range(1) ? 255 : 0;
        2: begin
          pix = base + $urandom_range(12) - 6;
          pix = (pix < 0) ? 0 : (pix > 255) ? 255 : pix;
        end
        default: pix = $urandom_range(255);
      endcase
      push_req(ir8_pkg::REQ_PIXEL, $urandom_range(31), pix,
               (gen_pos == 0) ? blk_md : $urandom_range(7));
    end
    total_items = pending_reqs.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
    while (expected_residuals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_residuals.size() != 0) log_error("residuals still outstanding at end");

    $display("Covered %0d requests and %0d residuals; responses held off %0d cycles once.",
             req_count, rsp_count, HOLD_CYCLES);
    $display("Blocks per mode V/H/DC/DDL/DDR/VR/HD/VL: %0d %0d %0d %0d %0d %0d %0d %0d",
             mode_blocks[ir8_pkg::MODE_VERTICAL], mode_blocks[ir8_pkg::MODE_HORIZONTAL],
             mode_blocks[ir8_pkg::MODE_DC], mode_blocks[ir8_pkg::MODE_DIAG_DL],
             mode_blocks[ir8_pkg::MODE_DIAG_DR], mode_blocks[ir8_pkg::MODE_VERT_RIGHT],
             mode_blocks[ir8_pkg::MODE_HORIZ_DOWN], mode_blocks[ir8_pkg::MODE_VERT_LEFT]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("Timed out with %0d residuals outstanding", expected_residuals.size());
    $display("FAIL");
    $finish;
  end

endmodule
